// ----- rtl/mcg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcg_pkg
// Types, constants and small tables shared by the month calendar grid blocks.
// ----------------------------------------------------------------------------
package mcg_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int IDX_W   = 6;
    localparam int ROW_W   = 3;
    localparam int COL_W   = 3;
    localparam int KIND_W  = 2;
    localparam int WDAY_W  = 3;
    localparam int CENT_W  = 8;   // year / 100 for a 14-bit year
    localparam int YMOD_W  = 7;   // year % 100
    localparam int SUM_W   = 10;  // zeller sum before mod 7
    localparam int DCNT_W  = 6;   // running day counter across the grid

    localparam int GRID_COLS = 7;

    // divide by 100 as multiply by 5243 then shift by 19, exact for 14-bit years
    localparam int DIV100_MUL   = 5243;
    localparam int DIV100_SHIFT = 19;
    localparam int DIV100_PW    = YEAR_W + 13;
    // mod 7 via multiply by 9363 then shift by 16, exact for 10-bit sums
    localparam int MOD7_MUL     = 9363;
    localparam int MOD7_SHIFT   = 16;
    localparam int MOD7_PW      = SUM_W + 14;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    localparam logic [KIND_W-1:0] KIND_PREV  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CUR   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NEXT  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TODAY = 2'd3;

    typedef struct packed {
        logic [YEAR_W-1:0]  view_year;
        logic [MONTH_W-1:0] view_month;
        logic [YEAR_W-1:0]  today_yr;
        logic [MONTH_W-1:0] today_month;
        logic [DAY_W-1:0]   today_mday;
    } mcg_req_t;

    typedef struct packed {
        logic [IDX_W-1:0]  cell_index;
        logic [ROW_W-1:0]  cell_row;
        logic [COL_W-1:0]  cell_column;
        logic [DAY_W-1:0]  shown_day;
        logic [KIND_W-1:0] cell_kind;
        logic              last_cell;
    } mcg_cell_t;

    // per-month layout handed from the header pipe to the cell generator
    typedef struct packed {
        logic [WDAY_W-1:0] first_wday;
        logic [DAY_W-1:0]  month_days;
        logic [DAY_W-1:0]  prev_days;
        logic              today_hit;
        logic [DAY_W-1:0]  today_mday;
    } mcg_hdr_t;

    // floor(13 * (m + 1) / 5)
    function automatic logic [5:0] month_term(input logic [MONTH_W-1:0] m);
        logic [5:0] t;
        case (m)
            4'd0:    t = 6'd2;
            4'd1:    t = 6'd5;
            4'd2:    t = 6'd7;
            4'd3:    t = 6'd10;
            4'd4:    t = 6'd13;
            4'd5:    t = 6'd15;
            4'd6:    t = 6'd18;
            4'd7:    t = 6'd20;
            4'd8:    t = 6'd23;
            4'd9:    t = 6'd26;
            4'd10:   t = 6'd28;
            4'd11:   t = 6'd31;
            4'd12:   t = 6'd33;
            4'd13:   t = 6'd36;
            4'd14:   t = 6'd39;
            default: t = 6'd41;
        endcase
        return t;
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] n;
        case (m)
            MONTH_FEB: n = leap ? 5'd29 : 5'd28;
            default:   n = (m inside {4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12})
                           ? 5'd31 : 5'd30;
        endcase
        return n;
    endfunction

    function automatic logic [MONTH_W-1:0] prev_month(input logic [MONTH_W-1:0] m);
        return (m > MONTH_JAN) ? m - 4'd1 : MONTH_DEC;
    endfunction

endpackage

// ----- rtl/mcg_header.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcg_header
// Four-stage pipe that turns a request into the month layout: weekday of the
// first by zeller's congruence, month lengths with the gregorian leap rule.
// ----------------------------------------------------------------------------
module mcg_header (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  mcg_pkg::mcg_req_t s_data,
    output logic              hdr_valid,
    input  logic              hdr_ready,
    output mcg_pkg::mcg_hdr_t hdr_data
);

    // stage enables: a stage loads when it is empty or its contents move on
    logic rdy1, rdy2, rdy3, rdy4;
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    assign rdy4    = !v4_reg || hdr_ready;
    assign rdy3    = !v3_reg || rdy4;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // ---------------- stage 1: zeller year, centuries ----------------
    logic [mcg_pkg::YEAR_W-1:0]      zy;
    logic [mcg_pkg::MONTH_W-1:0]     zm;
    logic [mcg_pkg::DIV100_PW-1:0]   pz, pv;

    always_comb begin
        if (s_data.view_month < mcg_pkg::MONTH_MAR) begin
            zy = s_data.view_year - 14'd1;
            zm = s_data.view_month + 4'd12;
        end else begin
            zy = s_data.view_year;
            zm = s_data.view_month;
        end
        pz = mcg_pkg::DIV100_PW'(zy) * mcg_pkg::DIV100_PW'(mcg_pkg::DIV100_MUL);
        pv = mcg_pkg::DIV100_PW'(s_data.view_year)
           * mcg_pkg::DIV100_PW'(mcg_pkg::DIV100_MUL);
    end

    logic [mcg_pkg::YEAR_W-1:0]  s1_zy_reg, s1_vy_reg;
    logic [mcg_pkg::MONTH_W-1:0] s1_zm_reg, s1_vm_reg;
    logic [mcg_pkg::CENT_W-1:0]  s1_jz_reg, s1_jv_reg;
    logic                        s1_hit_reg;
    logic [mcg_pkg::DAY_W-1:0]   s1_td_reg;

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            s1_zy_reg  <= zy;
            s1_zm_reg  <= zm;
            s1_vy_reg  <= s_data.view_year;
            s1_vm_reg  <= s_data.view_month;
            s1_jz_reg  <= pz[mcg_pkg::DIV100_SHIFT +: mcg_pkg::CENT_W];
            s1_jv_reg  <= pv[mcg_pkg::DIV100_SHIFT +: mcg_pkg::CENT_W];
            s1_hit_reg <= (s_data.today_yr == s_data.view_year)
                       && (s_data.today_month == s_data.view_month);
            s1_td_reg  <= s_data.today_mday;
        end
    end

    // ---------------- stage 2: year % 100, leap, lengths ----------------
    logic [mcg_pkg::YEAR_W-1:0] kz_full, kv_full;
    logic                       leap;

    always_comb begin
        kz_full = s1_zy_reg - 14'(15'(s1_jz_reg) * 15'd100);
        kv_full = s1_vy_reg - 14'(15'(s1_jv_reg) * 15'd100);
        // century years are leap only when the century count divides by 4
        leap    = (kv_full == '0) ? (s1_jv_reg[1:0] == 2'b00)
                                  : (s1_vy_reg[1:0] == 2'b00);
    end

    logic [mcg_pkg::YMOD_W-1:0]  s2_kz_reg;
    logic [mcg_pkg::CENT_W-1:0]  s2_jz_reg;
    logic [mcg_pkg::MONTH_W-1:0] s2_zm_reg;
    logic [mcg_pkg::DAY_W-1:0]   s2_len_reg, s2_plen_reg, s2_td_reg;
    logic                        s2_hit_reg;

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            s2_kz_reg   <= kz_full[mcg_pkg::YMOD_W-1:0];
            s2_jz_reg   <= s1_jz_reg;
            s2_zm_reg   <= s1_zm_reg;
            s2_len_reg  <= mcg_pkg::month_len(s1_vm_reg, leap);
            s2_plen_reg <= mcg_pkg::month_len(mcg_pkg::prev_month(s1_vm_reg), leap);
            s2_hit_reg  <= s1_hit_reg;
            s2_td_reg   <= s1_td_reg;
        end
    end

    // ---------------- stage 3: zeller sum ----------------
    logic [mcg_pkg::SUM_W-1:0] zsum;

    always_comb begin
        zsum = 10'd1
             + 10'(mcg_pkg::month_term(s2_zm_reg))
             + 10'(s2_kz_reg)
             + 10'(s2_kz_reg >> 2)
             + 10'(s2_jz_reg >> 2)
             + 10'(s2_jz_reg) * 10'd5;
    end

    logic [mcg_pkg::SUM_W-1:0]   s3_sum_reg;
    logic [mcg_pkg::DAY_W-1:0]   s3_len_reg, s3_plen_reg, s3_td_reg;
    logic                        s3_hit_reg;

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            s3_sum_reg  <= zsum;
            s3_len_reg  <= s2_len_reg;
            s3_plen_reg <= s2_plen_reg;
            s3_hit_reg  <= s2_hit_reg;
            s3_td_reg   <= s2_td_reg;
        end
    end

    // ---------------- stage 4: mod 7, shift to monday first ----------------
    logic [mcg_pkg::MOD7_PW-1:0] pq;
    logic [mcg_pkg::SUM_W-1:0]   r_full;
    logic [mcg_pkg::WDAY_W-1:0]  h, wday;

    always_comb begin
        pq     = mcg_pkg::MOD7_PW'(s3_sum_reg) * mcg_pkg::MOD7_PW'(mcg_pkg::MOD7_MUL);
        r_full = s3_sum_reg
               - 10'(pq[mcg_pkg::MOD7_SHIFT +: (mcg_pkg::MOD7_PW - mcg_pkg::MOD7_SHIFT)])
               * 10'd7;
        h      = r_full[mcg_pkg::WDAY_W-1:0];
        // zeller 0 is saturday; (h + 5) % 7
        wday   = (h >= 3'd2) ? h - 3'd2 : h + 3'd5;
    end

    mcg_pkg::mcg_hdr_t s4_hdr_reg;

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            s4_hdr_reg.first_wday <= wday;
            s4_hdr_reg.month_days <= s3_len_reg;
            s4_hdr_reg.prev_days  <= s3_plen_reg;
            s4_hdr_reg.today_hit  <= s3_hit_reg;
            s4_hdr_reg.today_mday <= s3_td_reg;
        end
    end

    assign hdr_valid = v4_reg;
    assign hdr_data  = s4_hdr_reg;

endmodule

// ----- rtl/mcg_cell_gen.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcg_cell_gen
// Walks the grid from a month layout, one cell per unstalled cycle, and drives the
// registered result channel. Takes the next layout on the last cell's beat.
// ----------------------------------------------------------------------------
module mcg_cell_gen #(
    parameter int unsigned GRID_ROWS = 6
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               hdr_valid,
    output logic               hdr_ready,
    input  mcg_pkg::mcg_hdr_t  hdr_data,
    output logic               m_valid,
    input  logic               m_ready,
    output mcg_pkg::mcg_cell_t m_data
);

    localparam int unsigned NUM_CELLS = GRID_ROWS * mcg_pkg::GRID_COLS;
    localparam logic [mcg_pkg::IDX_W-1:0] LAST_IDX = mcg_pkg::IDX_W'(NUM_CELLS - 1);
    localparam logic [mcg_pkg::COL_W-1:0] LAST_COL = mcg_pkg::COL_W'(mcg_pkg::GRID_COLS - 1);

    mcg_pkg::mcg_hdr_t             hdr_reg;
    logic                          busy_reg;
    logic [mcg_pkg::IDX_W-1:0]     idx_reg;
    logic [mcg_pkg::ROW_W-1:0]     row_reg;
    logic [mcg_pkg::COL_W-1:0]     col_reg;
    logic [mcg_pkg::DCNT_W-1:0]    day_reg;
    logic                          m_valid_reg;
    mcg_pkg::mcg_cell_t            m_data_reg;

    logic                          out_take, produce, is_last, is_prev, is_cur, load;
    logic [mcg_pkg::DCNT_W-1:0]    prev_shown;
    mcg_pkg::mcg_cell_t            m_data_next;

    assign out_take  = !m_valid_reg || m_ready;
    assign produce   = busy_reg && out_take;
    assign is_last   = (idx_reg == LAST_IDX);
    assign hdr_ready = !busy_reg || (produce && is_last);
    assign load      = hdr_valid && hdr_ready;

    always_comb begin
        is_prev    = idx_reg < mcg_pkg::IDX_W'(hdr_reg.first_wday);
        is_cur     = day_reg <= mcg_pkg::DCNT_W'(hdr_reg.month_days);
        prev_shown = mcg_pkg::DCNT_W'(hdr_reg.prev_days)
                   - mcg_pkg::DCNT_W'(hdr_reg.first_wday)
                   + idx_reg + 6'd1;

        m_data_next.cell_index  = idx_reg;
        m_data_next.cell_row    = row_reg;
        m_data_next.cell_column = col_reg;
        m_data_next.last_cell   = is_last;
        if (is_prev) begin
            m_data_next.shown_day = prev_shown[mcg_pkg::DAY_W-1:0];
            m_data_next.cell_kind = mcg_pkg::KIND_PREV;
        end else if (is_cur) begin
            m_data_next.shown_day = day_reg[mcg_pkg::DAY_W-1:0];
            m_data_next.cell_kind = (hdr_reg.today_hit
                                    && mcg_pkg::DCNT_W'(hdr_reg.today_mday) == day_reg)
                                  ? mcg_pkg::KIND_TODAY : mcg_pkg::KIND_CUR;
        end else begin
            m_data_next.shown_day =
                mcg_pkg::DAY_W'(day_reg - mcg_pkg::DCNT_W'(hdr_reg.month_days));
            m_data_next.cell_kind = mcg_pkg::KIND_NEXT;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            hdr_reg <= hdr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            row_reg  <= '0;
            col_reg  <= '0;
            day_reg  <= 6'd1;
        end else if (load) begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
            row_reg  <= '0;
            col_reg  <= '0;
            day_reg  <= 6'd1;
        end else if (produce) begin
            busy_reg <= !is_last;
            idx_reg  <= idx_reg + 6'd1;
            if (col_reg == LAST_COL) begin
                col_reg <= '0;
                row_reg <= row_reg + 3'd1;
            end else begin
                col_reg <= col_reg + 3'd1;
            end
            // day count starts at the first of the month
            if (!is_prev) begin
                day_reg <= day_reg + 6'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_take) begin
            m_valid_reg <= busy_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (produce) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- rtl/month_calendar_grid_generator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// month_calendar_grid_generator
// Lays out one month as a monday-first grid of GRID_ROWS x 7 cells.
//
//   channel   direction  payload               beats per request
//   s_        in         mcg_req_t             1
//   m_        out        mcg_cell_t            GRID_ROWS * 7
//
// A request passes the four header pipe stages, then the cell generator's
// layout register, before its first cell beat is registered at the output.
// Cells leave at one beat per cycle while m_ready allows, from a single cell
// counter, and the next request's layout is taken on the last cell's beat.
// Up to four further requests queue in the header pipe while cells stream.
// Reset (synchronous, active low) clears all valid bits and counters.
// A stall on m_ holds the output register and backs up the pipe; no beat is
// lost or repeated.
// ----------------------------------------------------------------------------
module month_calendar_grid_generator #(
    parameter int unsigned GRID_ROWS = 6
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  mcg_pkg::mcg_req_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output mcg_pkg::mcg_cell_t m_data
);

    logic              hdr_valid;
    logic              hdr_ready;
    mcg_pkg::mcg_hdr_t hdr_data;

    mcg_header u_header (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .hdr_valid (hdr_valid),
        .hdr_ready (hdr_ready),
        .hdr_data  (hdr_data)
    );

    mcg_cell_gen #(
        .GRID_ROWS (GRID_ROWS)
    ) u_cell_gen (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .hdr_valid (hdr_valid),
        .hdr_ready (hdr_ready),
        .hdr_data  (hdr_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ----- rtl/mcg_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcg_checker
// Port-level checks on the calendar grid output, bound to the top level.
// ----------------------------------------------------------------------------
module mcg_checker #(
    parameter int unsigned GRID_ROWS = 6
) (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input mcg_pkg::mcg_cell_t m_data
);

    localparam logic [mcg_pkg::IDX_W-1:0] LAST_IDX =
        mcg_pkg::IDX_W'(GRID_ROWS * mcg_pkg::GRID_COLS - 1);

    // a stalled beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled output beat changed");

    // row and column agree with the cell number
    a_coord: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (7'(m_data.cell_row) * 7'd7 + 7'(m_data.cell_column))
                    == 7'(m_data.cell_index))
        else $error("cell coordinates disagree with index");

    // last flag only on the final cell
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.last_cell == (m_data.cell_index == LAST_IDX)))
        else $error("last cell flag misplaced");

    // previous month tail fits in the first row and shows late days
    a_prev: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.cell_kind == mcg_pkg::KIND_PREV)
        |-> (m_data.cell_row == 3'd0) && (m_data.shown_day >= 5'd22))
        else $error("previous month cell out of place");

    // nothing comes out right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

bind month_calendar_grid_generator mcg_checker #(
    .GRID_ROWS (GRID_ROWS)
) u_mcg_checker (.*);

// ----- bench/month_calendar_grid_generator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// month_calendar_grid_generator_tb
// Sends calendar requests (view month plus today's date) and checks every
// cell beat of the returned grid against a behavioral model of the layout.
// A short table of hand-picked dates is followed by random requests, with
// random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module month_calendar_grid_generator_tb;

    localparam int GRID_ROWS   = 6;
    localparam int CELLS       = GRID_ROWS * mcg_pkg::GRID_COLS;
    localparam int N_RANDOM    = 440;
    localparam int TAIL_CYCLES = 32;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        mcg_pkg::mcg_req_t          req;
        logic                       pinned;    // first cell typed in by hand
        logic [mcg_pkg::DAY_W-1:0]  day0;
        logic [mcg_pkg::KIND_W-1:0] kind0;
    } month_row_t;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    mcg_pkg::mcg_req_t  s_data  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    mcg_pkg::mcg_cell_t m_data;

    mcg_pkg::mcg_cell_t cells_due[$];
    month_row_t         month_plan[$];
    int                 bad_cells = 0;
    int                 cycle_no  = 0;

    month_calendar_grid_generator #(
        .GRID_ROWS(GRID_ROWS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // grid model
    // ------------------------------------------------------------------
    function automatic int unsigned days_in(int unsigned y, int unsigned m);
        bit leap;
        leap = (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            2:                     return leap ? 29 : 28;
            default:               return 30;
        endcase
    endfunction

    // weekday of the 1st, monday = 0
    function automatic int unsigned monday_offset(int unsigned y, int unsigned m);
        int unsigned zy, zm, k, j, h;
        zy = y;
        zm = m;
        if (zm < 3) begin
            // jan/feb count as months 13/14 of the year before, year wraps at 14 bits
            zm = zm + 12;
            zy = (zy - 1) & 32'h3fff;
        end
        k = zy % 100;
        j = zy / 100;
        h = (1 + (13 * (zm + 1)) / 5 + k + k / 4 + j / 4 + 5 * j) % 7;
        return (h + 5) % 7;
    endfunction

    function automatic void lay_out_month(input mcg_pkg::mcg_req_t r);
        int unsigned        vy, vm, first, len, prev_len, day, i;
        mcg_pkg::mcg_cell_t c;
        vy       = r.view_year;
        vm       = r.view_month;
        first    = monday_offset(vy, vm);
        len      = days_in(vy, vm);
        prev_len = days_in(vy, (vm > 1) ? vm - 1 : 12);
        day      = 1;
        for (i = 0; i < CELLS; i++) begin
            c.cell_index  = mcg_pkg::IDX_W'(i);
            c.cell_row    = mcg_pkg::ROW_W'(i / mcg_pkg::GRID_COLS);
            c.cell_column = mcg_pkg::COL_W'(i % mcg_pkg::GRID_COLS);
            c.last_cell   = (i == CELLS - 1);
            if (i < first) begin
                c.shown_day = mcg_pkg::DAY_W'(prev_len - first + i + 1);
                c.cell_kind = mcg_pkg::KIND_PREV;
            end else if (day <= len) begin
                c.shown_day = mcg_pkg::DAY_W'(day);
                c.cell_kind = (r.today_yr == r.view_year
                               && r.today_month == r.view_month
                               && r.today_mday == day)
                            ? mcg_pkg::KIND_TODAY : mcg_pkg::KIND_CUR;
                day++;
            end else begin
                c.shown_day = mcg_pkg::DAY_W'(day - len);
                c.cell_kind = mcg_pkg::KIND_NEXT;
                day++;
            end
            cells_due.push_back(c);
        end
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic void add_row(int vy, int vm, int ty, int tm, int td,
                                    bit pinned = 1'b0, int day0 = 0,
                                    logic [mcg_pkg::KIND_W-1:0] kind0 = mcg_pkg::KIND_PREV);
        month_row_t row;
        row.req.view_year   = mcg_pkg::YEAR_W'(vy);
        row.req.view_month  = mcg_pkg::MONTH_W'(vm);
        row.req.today_yr    = mcg_pkg::YEAR_W'(ty);
        row.req.today_month = mcg_pkg::MONTH_W'(tm);
        row.req.today_mday  = mcg_pkg::DAY_W'(td);
        row.pinned          = pinned;
        row.day0            = mcg_pkg::DAY_W'(day0);
        row.kind0           = kind0;
        month_plan.push_back(row);
    endfunction

    function automatic mcg_pkg::mcg_req_t random_month();
        mcg_pkg::mcg_req_t r;
        int                pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            r.view_year  = mcg_pkg::YEAR_W'($urandom_range(1, 9999));
            r.view_month = mcg_pkg::MONTH_W'($urandom_range(1, 12));
            case ($urandom_range(0, 3))
                0, 1: begin
                    // same month, so today can land on any day, valid or not
                    r.today_yr    = r.view_year;
                    r.today_month = r.view_month;
                    r.today_mday  = mcg_pkg::DAY_W'($urandom_range(1, 31));
                end
                2: begin
                    r.today_yr    = r.view_year;
                    r.today_month = mcg_pkg::MONTH_W'($urandom_range(1, 12));
                    r.today_mday  = mcg_pkg::DAY_W'($urandom_range(1, 31));
                end
                default: begin
                    r.today_yr    = mcg_pkg::YEAR_W'($urandom_range(1, 9999));
                    r.today_month = mcg_pkg::MONTH_W'($urandom_range(1, 12));
                    r.today_mday  = mcg_pkg::DAY_W'($urandom_range(1, 28));
                end
            endcase
        end else begin
            r = mcg_pkg::mcg_req_t'($urandom);
            r.view_year = mcg_pkg::YEAR_W'($urandom);
            r.today_yr  = ($urandom_range(0, 1) == 1) ? r.view_year
                                                      : mcg_pkg::YEAR_W'($urandom);
        end
        return r;
    endfunction

    function automatic int sender_gap(bit calm);
        int pick;
        pick = $urandom_range(0, 99);
        if (calm || pick < 60) return 0;
        if (pick < 92)         return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic check_field(input string what, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            bad_cells++;
            if (bad_cells <= MAX_REPORTS)
                $display("%0t: %s expected %0d got %0d", $time, what, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------
    initial begin : stimulus
        month_row_t row;
        int         total, gap, base, i;
        bit         calm;

        // hand-picked months; first cell typed in where it is plain from the calendar
        add_row(2024, 1, 2024, 1, 1, 1'b1, 1, mcg_pkg::KIND_TODAY);  // starts on a monday
        add_row(2024, 1, 2023, 12, 31, 1'b1, 1, mcg_pkg::KIND_CUR);
        add_row(2000, 1, 0, 0, 0, 1'b1, 27, mcg_pkg::KIND_PREV);      // saturday start
        add_row(2024, 9, 2024, 9, 30, 1'b1, 26, mcg_pkg::KIND_PREV);  // sunday start, 30 days
        add_row(2024, 3, 2024, 3, 31, 1'b1, 26, mcg_pkg::KIND_PREV);  // prev month is leap feb
        add_row(2021, 2, 2021, 2, 28, 1'b1, 1, mcg_pkg::KIND_CUR);    // exactly four rows
        add_row(2024, 12, 2024, 12, 25);                        // sunday start, 31 days
        add_row(2024, 2, 2024, 2, 29);
        add_row(1900, 2, 1900, 2, 29);                          // century, not leap
        add_row(2000, 2, 2000, 2, 29);                          // 400 rule, leap
        add_row(0, 1, 0, 1, 1);                                 // year zero wraps
        add_row(0, 2, 0, 2, 29);
        add_row(0, 3, 0, 3, 1);
        add_row(16383, 12, 16383, 12, 31);
        add_row(9999, 12, 9999, 12, 31);
        add_row(1, 1, 1, 1, 1);
        add_row(2023, 0, 2023, 0, 5);                           // month zero
        add_row(2023, 13, 2023, 13, 30);
        add_row(2023, 14, 2023, 14, 1);
        add_row(2023, 15, 16383, 15, 31);
        add_row(2023, 4, 2023, 4, 31);                          // day past month end
        add_row(2023, 6, 2023, 6, 0);                           // day zero
        add_row(2023, 12, 2023, 11, 15);
        add_row(2024, 5, 2023, 5, 10);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        total = month_plan.size() + N_RANDOM;
        calm  = 1'b0;
        for (i = 0; i < total; i++) begin
            if (i < month_plan.size()) begin
                row = month_plan[i];
            end else begin
                row.req    = random_month();
                row.pinned = 1'b0;
                row.day0   = '0;
                row.kind0  = mcg_pkg::KIND_PREV;
            end
            if ($urandom_range(0, 39) == 0)
                calm = !calm;

            if (i == month_plan.size() || i == month_plan.size() + N_RANDOM / 2) begin
                // hold off until the grid stream has fully drained
                s_valid <= 1'b0;
                @(posedge aclk);
                while (cells_due.size() != 0) @(posedge aclk);
            end else begin
                gap = sender_gap(calm);
                if (gap > 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end

            s_valid <= 1'b1;
            s_data  <= row.req;
            @(posedge aclk);
            while (!s_ready) @(posedge aclk);

            base = cells_due.size();
            lay_out_month(row.req);
            if (row.pinned) begin
                cells_due[base].shown_day = row.day0;
                cells_due[base].cell_kind = row.kind0;
            end
        end
        s_valid <= 1'b0;

        while (cells_due.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        @(negedge aclk);
        if (bad_cells == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // cell side: back-pressure and checking
    // ------------------------------------------------------------------
    int hold_cnt  = 0;
    bit rx_calm   = 1'b0;

    always @(posedge aclk) begin : rx_pace
        int pick;
        pick = $urandom_range(0, 99);
        if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
            m_ready  <= 1'b0;
        end else if (rx_calm || pick < 70) begin
            m_ready <= 1'b1;
        end else if (pick < 96) begin
            m_ready  <= 1'b0;
            hold_cnt <= $urandom_range(0, 2);
        end else begin
            m_ready  <= 1'b0;
            hold_cnt <= $urandom_range(5, 20);
        end
        if ($urandom_range(0, 199) == 0)
            rx_calm <= !rx_calm;
    end

    always @(posedge aclk) begin : cell_check
        mcg_pkg::mcg_cell_t want;
        if (aresetn && m_valid && m_ready) begin
            if (cells_due.size() == 0) begin
                bad_cells++;
                if (bad_cells <= MAX_REPORTS)
                    $display("%0t: unexpected cell beat, expected none got %p",
                             $time, m_data);
            end else begin
                want = cells_due.pop_front();
                check_field("cell_index",  8'(want.cell_index),  8'(m_data.cell_index));
                check_field("cell_row",    8'(want.cell_row),    8'(m_data.cell_row));
                check_field("cell_column", 8'(want.cell_column), 8'(m_data.cell_column));
                check_field("shown_day",   8'(want.shown_day),   8'(m_data.shown_day));
                check_field("cell_kind",   8'(want.cell_kind),   8'(m_data.cell_kind));
                check_field("last_cell",   8'(want.last_cell),   8'(m_data.last_cell));
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        cycle_no++;
        if (cycle_no >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

endmodule

// ----- sim.f -----
rtl/mcg_pkg.sv
rtl/mcg_header.sv
rtl/mcg_cell_gen.sv
rtl/month_calendar_grid_generator.sv
rtl/mcg_checker.sv
bench/month_calendar_grid_generator_tb.sv
